// ----- rtl/core/plsu_pkg.sv -----
// Shared types, widths and constants of the position loop settle unit.
`default_nettype none

package plsu_pkg;

    // Field widths of the stream items and registers
    localparam int ENCODER_WIDTH  = 16;
    localparam int INTEGRAL_WIDTH = 24;
    localparam int TARGET_W       = 16;
    localparam int GAIN_W         = 16;
    localparam int LIMIT_W        = 7;
    localparam int SAMPLE_W       = 8;
    localparam int POWER_W        = 8;
    localparam int POS_W          = 19;
    localparam int TIMER_W        = 17;

    // Error is target - 2*count, exact
    localparam int ERR_W  = ((ENCODER_WIDTH + 1 > TARGET_W) ? ENCODER_WIDTH + 1 : TARGET_W) + 1;
    localparam int DIFF_W = ERR_W + 1;
    localparam int ACC_W  = ((INTEGRAL_WIDTH > ERR_W) ? INTEGRAL_WIDTH : ERR_W) + 1;
    localparam int EXT_W  = (ERR_W > POS_W) ? ERR_W : POS_W;

    // Products of signed operands with the unsigned gains (one guard bit)
    localparam int GAINS_W = GAIN_W + 1;
    localparam int PP_W    = GAINS_W + ERR_W;
    localparam int PI_W    = GAINS_W + INTEGRAL_WIDTH;
    localparam int PD_W    = GAINS_W + DIFF_W;
    localparam int SUM_W   = ((PD_W > PI_W) ? PD_W : PI_W) + 2;

    // Q4.12 gains
    localparam int Q_SHIFT = 12;

    localparam int NEAR_LIMIT   = 30;
    localparam int SETTLE_FLOOR = 250;

    // Stream widths, whole bytes
    localparam int IN_TDATA_W  = ((ENCODER_WIDTH + 7) / 8) * 8;
    localparam int OUT_FIELD_W = POWER_W + 1 + POS_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_TICKS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_ZONE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_POWER_LIMIT   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_MS     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_MS     = 3'd7;

    // Register reset values
    localparam logic [TARGET_W-1:0] RST_TARGET_TICKS  = 16'd0;
    localparam logic [GAIN_W-1:0]   RST_GAIN_P        = 16'd1065;
    localparam logic [GAIN_W-1:0]   RST_GAIN_I        = 16'd205;
    localparam logic [GAIN_W-1:0]   RST_GAIN_D        = 16'd2540;
    localparam logic [15:0]         RST_INTEGRAL_ZONE = 16'd299;
    localparam logic [LIMIT_W-1:0]  RST_POWER_LIMIT   = 7'd127;
    localparam logic [15:0]         RST_SETTLE_MS     = 16'd250;
    localparam logic [SAMPLE_W-1:0] RST_SAMPLE_MS     = 8'd40;

    // Input command codes
    localparam logic CMD_SAMPLE  = 1'b0;
    localparam logic CMD_RESTART = 1'b1;

    typedef struct packed {
        logic signed [TARGET_W-1:0] target_ticks;
        logic [GAIN_W-1:0]          gain_p;
        logic [GAIN_W-1:0]          gain_i;
        logic [GAIN_W-1:0]          gain_d;
        logic [15:0]                integral_zone;
        logic [LIMIT_W-1:0]         power_limit;
        logic [15:0]                settle_ms;
        logic [SAMPLE_W-1:0]        sample_ms;
    } t_cfg;

    typedef struct packed {
        logic                            command;
        logic signed [ENCODER_WIDTH-1:0] encoder_count;
    } t_in_item;

    typedef struct packed {
        logic signed [INTEGRAL_WIDTH-1:0] integral_sum;
        logic signed [ERR_W-1:0]          previous_error;
        logic                             near_target_latch;
        logic [TIMER_W-1:0]               settle_timer;
        logic                             done_flag;
    } t_loop_state;

    // Operands handed from the state update to the multipliers
    typedef struct packed {
        logic                             kill;
        logic                             finished;
        logic signed [ERR_W-1:0]          err;
        logic signed [INTEGRAL_WIDTH-1:0] integral_sum;
        logic signed [DIFF_W-1:0]         diff;
    } t_ops;

    typedef struct packed {
        logic                    kill;
        logic                    finished;
        logic signed [ERR_W-1:0] err;
        logic signed [PP_W-1:0]  prod_p;
        logic signed [PI_W-1:0]  prod_i;
        logic signed [PD_W-1:0]  prod_d;
    } t_prods;

endpackage

`default_nettype wire

// ----- rtl/core/plsu_state_update.sv -----
// Error, integral zone, derivative difference and settle timer: next loop state.
`default_nettype none

module plsu_state_update (
    input  wire plsu_pkg::t_in_item    i_item,
    input  wire plsu_pkg::t_loop_state i_state,
    input  wire plsu_pkg::t_cfg        i_cfg,
    output plsu_pkg::t_loop_state      o_n_state,
    output plsu_pkg::t_ops             o_ops
);

    localparam int ERR_W  = plsu_pkg::ERR_W;
    localparam int ACC_W  = plsu_pkg::ACC_W;
    localparam int IW     = plsu_pkg::INTEGRAL_WIDTH;
    localparam int DIFF_W = plsu_pkg::DIFF_W;
    localparam int TW     = plsu_pkg::TIMER_W;

    localparam logic signed [ACC_W-1:0] IMAX = ACC_W'((64'sd1 <<< (IW - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] IMIN = ACC_W'(-(64'sd1 <<< (IW - 1)));
    localparam logic signed [ERR_W-1:0] NEAR = ERR_W'(plsu_pkg::NEAR_LIMIT);
    localparam logic [15:0]             FLOOR = 16'(plsu_pkg::SETTLE_FLOOR);
    localparam logic [TW-1:0]           TMAX = {TW{1'b1}};

    logic signed [ERR_W-1:0]  err;
    logic [ERR_W-1:0]         abs_err;
    logic                     in_zone;
    logic signed [ACC_W-1:0]  acc;
    logic signed [IW-1:0]     isum_next;
    logic signed [DIFF_W-1:0] diff;
    logic                     latch_next;
    logic [TW:0]              timer_sum;
    logic [TW-1:0]            timer_next;
    logic [15:0]              settle_need;
    logic                     done_next;

    always_comb begin
        err     = ERR_W'(i_cfg.target_ticks) - (ERR_W'(i_item.encoder_count) <<< 1);
        abs_err = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
        in_zone = (err != '0) && (abs_err < ERR_W'(i_cfg.integral_zone));

        // Saturating integral, cleared outside the zone
        acc = ACC_W'(i_state.integral_sum) + ACC_W'(err);
        if (!in_zone) begin
            isum_next = '0;
        end else if (acc > IMAX) begin
            isum_next = IMAX[IW-1:0];
        end else if (acc < IMIN) begin
            isum_next = IMIN[IW-1:0];
        end else begin
            isum_next = acc[IW-1:0];
        end

        // Zero error forces the derivative to zero
        if (err == '0) begin
            diff = '0;
        end else begin
            diff = DIFF_W'(err) - DIFF_W'(i_state.previous_error);
        end

        latch_next = i_state.near_target_latch || (err < NEAR);
        timer_sum  = {1'b0, i_state.settle_timer} + (TW + 1)'(i_cfg.sample_ms);
        if (!latch_next) begin
            timer_next = '0;
        end else if (timer_sum[TW]) begin
            timer_next = TMAX;
        end else begin
            timer_next = timer_sum[TW-1:0];
        end
        settle_need = (i_cfg.settle_ms < FLOOR) ? FLOOR : i_cfg.settle_ms;
        done_next   = timer_next >= TW'(settle_need);

        if (i_item.command == plsu_pkg::CMD_RESTART) begin
            o_n_state       = '0;
            o_ops           = '0;
            o_ops.kill      = 1'b1;
        end else if (i_state.done_flag) begin
            // Finished: state frozen, power zero, error still reported
            o_n_state       = i_state;
            o_ops           = '0;
            o_ops.kill      = 1'b1;
            o_ops.finished  = 1'b1;
            o_ops.err       = err;
        end else begin
            o_n_state.integral_sum      = isum_next;
            o_n_state.previous_error    = err;
            o_n_state.near_target_latch = latch_next;
            o_n_state.settle_timer      = timer_next;
            o_n_state.done_flag         = done_next;
            o_ops.kill                  = 1'b0;
            o_ops.finished              = done_next;
            o_ops.err                   = err;
            o_ops.integral_sum          = isum_next;
            o_ops.diff                  = diff;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/plsu_power_clamp.sv -----
// Sum of the three weighted terms, truncation toward zero and power clamp.
`default_nettype none

module plsu_power_clamp (
    input  wire plsu_pkg::t_prods                  i_prods,
    input  wire [plsu_pkg::LIMIT_W-1:0]            i_power_limit,
    output logic signed [plsu_pkg::POWER_W-1:0]    o_drive_power
);

    localparam int PD_W  = plsu_pkg::PD_W;
    localparam int SUM_W = plsu_pkg::SUM_W;
    localparam int QS    = plsu_pkg::Q_SHIFT;

    localparam logic signed [PD_W-1:0]  RND_D = PD_W'((64'sd1 <<< QS) - 64'sd1);
    localparam logic signed [SUM_W-1:0] RND_S = SUM_W'((64'sd1 <<< QS) - 64'sd1);

    logic signed [PD_W-1:0]  rnd_d;
    logic signed [PD_W-1:0]  d_adj;
    logic signed [PD_W-1:0]  d_trunc;
    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] rnd_s;
    logic signed [SUM_W-1:0] sum_adj;
    logic signed [SUM_W-1:0] quot;
    logic signed [SUM_W-1:0] lim_pos;
    logic signed [SUM_W-1:0] lim_neg;

    always_comb begin
        // Derivative term truncated toward zero to a whole multiple of 2^QS
        rnd_d   = i_prods.prod_d[PD_W-1] ? RND_D : '0;
        d_adj   = i_prods.prod_d + rnd_d;
        d_trunc = $signed({d_adj[PD_W-1:QS], {QS{1'b0}}});

        sum     = SUM_W'(i_prods.prod_p) + SUM_W'(i_prods.prod_i) + SUM_W'(d_trunc);
        rnd_s   = sum[SUM_W-1] ? RND_S : '0;
        sum_adj = sum + rnd_s;
        quot    = sum_adj >>> QS;

        lim_pos = SUM_W'($signed({1'b0, i_power_limit}));
        lim_neg = -lim_pos;

        if (i_prods.kill) begin
            o_drive_power = '0;
        end else if (quot > lim_pos) begin
            o_drive_power = lim_pos[plsu_pkg::POWER_W-1:0];
        end else if (quot < lim_neg) begin
            o_drive_power = lim_neg[plsu_pkg::POWER_W-1:0];
        end else begin
            o_drive_power = quot[plsu_pkg::POWER_W-1:0];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/pid_position_loop_settle_unit.sv -----
// Top level of the PID position loop with integral zone and settle timer.
`default_nettype none

// PID position loop for a drive base. Each input transfer carries one
// left-wheel encoder count (tdata) and a command bit (tuser: 0 = sample,
// 1 = restart). The error is target_ticks - 2*count; proportional, zoned
// integral and derivative terms with unsigned Q4.12 gains are summed,
// truncated toward zero and clamped to +-power_limit. Once the error has
// gone below 30 a settle timer adds sample_ms per sample; when it reaches
// max(settle_ms, 250) the move is finished and later results carry zero
// power with finished set, while the error is still reported. A restart
// transfer clears the loop state and returns an all-zero result.
// Rate: one transfer per cycle sustained unless the output stalls. The
// input register loads at the input transfer, then the state-update,
// multiplier and result registers follow in that order. The loop state
// closes its feedback in the single state-update stage, so each sample
// sees the state left by the one before it. Back-pressure on the output
// stalls the chain stage by stage, no bubbles are lost.
// Configuration writes take effect at the next edge and are expected only
// while the unit holds no transfer in flight.

module pid_position_loop_settle_unit (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    // configuration write port
    input  wire                                   i_cfg_we,
    input  wire [plsu_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire [plsu_pkg::CFG_DATA_W-1:0]        i_cfg_wdata,
    // sample stream in
    input  wire                                   i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    input  wire [plsu_pkg::IN_TDATA_W-1:0]        i_s_axis_tdata,  // [15:0] encoder_count
    input  wire [0:0]                             i_s_axis_tuser,  // [0] command
    // result stream out
    output logic                                  o_m_axis_tvalid,
    input  wire                                   i_m_axis_tready,
    // [7:0] drive_power, [8] finished, [27:9] position_error, rest zero
    output logic [plsu_pkg::OUT_TDATA_W-1:0]      o_m_axis_tdata
);

    localparam int PP_W = plsu_pkg::PP_W;
    localparam int PI_W = plsu_pkg::PI_W;
    localparam int PD_W = plsu_pkg::PD_W;

    plsu_pkg::t_cfg        r_cfg;
    plsu_pkg::t_loop_state r_state;
    plsu_pkg::t_loop_state n_state;
    plsu_pkg::t_in_item    r_s1;
    plsu_pkg::t_ops        r_s2;
    plsu_pkg::t_ops        n_ops;
    plsu_pkg::t_prods      r_s3;

    logic r_v1, r_v2, r_v3, r_vo;
    logic w_rdy1, w_rdy2, w_rdy3, w_rdyo;
    logic w_mv1;

    logic signed [plsu_pkg::POWER_W-1:0] w_power;
    logic signed [plsu_pkg::POWER_W-1:0] r_out_power;
    logic                                r_out_finished;
    logic signed [plsu_pkg::POS_W-1:0]   r_out_pos;
    logic signed [plsu_pkg::EXT_W-1:0]   w_err_ext;

    // Stage-by-stage ready: a stage takes new data when empty or draining
    assign w_rdyo = !r_vo || i_m_axis_tready;
    assign w_rdy3 = !r_v3 || w_rdyo;
    assign w_rdy2 = !r_v2 || w_rdy3;
    assign w_rdy1 = !r_v1 || w_rdy2;
    assign w_mv1  = r_v1 && w_rdy2;

    assign o_s_axis_tready = w_rdy1;
    assign o_m_axis_tvalid = r_vo;
    assign o_m_axis_tdata  = plsu_pkg::OUT_TDATA_W'({r_out_pos, r_out_finished, r_out_power});

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_ticks  <= plsu_pkg::RST_TARGET_TICKS;
            r_cfg.gain_p        <= plsu_pkg::RST_GAIN_P;
            r_cfg.gain_i        <= plsu_pkg::RST_GAIN_I;
            r_cfg.gain_d        <= plsu_pkg::RST_GAIN_D;
            r_cfg.integral_zone <= plsu_pkg::RST_INTEGRAL_ZONE;
            r_cfg.power_limit   <= plsu_pkg::RST_POWER_LIMIT;
            r_cfg.settle_ms     <= plsu_pkg::RST_SETTLE_MS;
            r_cfg.sample_ms     <= plsu_pkg::RST_SAMPLE_MS;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                plsu_pkg::CFG_TARGET_TICKS:  r_cfg.target_ticks  <= $signed(i_cfg_wdata);
                plsu_pkg::CFG_GAIN_P:        r_cfg.gain_p        <= i_cfg_wdata;
                plsu_pkg::CFG_GAIN_I:        r_cfg.gain_i        <= i_cfg_wdata;
                plsu_pkg::CFG_GAIN_D:        r_cfg.gain_d        <= i_cfg_wdata;
                plsu_pkg::CFG_INTEGRAL_ZONE: r_cfg.integral_zone <= i_cfg_wdata;
                plsu_pkg::CFG_POWER_LIMIT:
                    r_cfg.power_limit <= i_cfg_wdata[plsu_pkg::LIMIT_W-1:0];
                plsu_pkg::CFG_SETTLE_MS:     r_cfg.settle_ms     <= i_cfg_wdata;
                plsu_pkg::CFG_SAMPLE_MS:
                    r_cfg.sample_ms <= i_cfg_wdata[plsu_pkg::SAMPLE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Valid bits and loop state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_vo    <= 1'b0;
            r_state <= '0;
        end else begin
            if (w_rdy1) begin
                r_v1 <= i_s_axis_tvalid;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
            if (w_rdy3) begin
                r_v3 <= r_v2;
            end
            if (w_rdyo) begin
                r_vo <= r_v3;
            end
            if (w_mv1) begin
                r_state <= n_state;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_s_axis_tvalid) begin
            r_s1.command       <= i_s_axis_tuser[0];
            r_s1.encoder_count <= $signed(i_s_axis_tdata[plsu_pkg::ENCODER_WIDTH-1:0]);
        end
        if (w_mv1) begin
            r_s2 <= n_ops;
        end
        if (r_v2 && w_rdy3) begin
            r_s3.kill     <= r_s2.kill;
            r_s3.finished <= r_s2.finished;
            r_s3.err      <= r_s2.err;
            r_s3.prod_p   <= PP_W'($signed({1'b0, r_cfg.gain_p})) * PP_W'(r_s2.err);
            r_s3.prod_i   <= PI_W'($signed({1'b0, r_cfg.gain_i})) * PI_W'(r_s2.integral_sum);
            r_s3.prod_d   <= PD_W'($signed({1'b0, r_cfg.gain_d})) * PD_W'(r_s2.diff);
        end
        if (r_v3 && w_rdyo) begin
            r_out_power    <= w_power;
            r_out_finished <= r_s3.finished;
            r_out_pos      <= w_err_ext[plsu_pkg::POS_W-1:0];
        end
    end

    assign w_err_ext = plsu_pkg::EXT_W'(r_s3.err);

    plsu_state_update u_state_update (
        .i_item    (r_s1),
        .i_state   (r_state),
        .i_cfg     (r_cfg),
        .o_n_state (n_state),
        .o_ops     (n_ops)
    );

    plsu_power_clamp u_power_clamp (
        .i_prods       (r_s3),
        .i_power_limit (r_cfg.power_limit),
        .o_drive_power (w_power)
    );

`ifndef SYNTHESIS
    // Power never leaves the configured band
    a_power_in_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vo |-> ((r_out_power[7] ? 8'(-r_out_power) : 8'(r_out_power))
                  <= {1'b0, r_cfg.power_limit}))
        else $error("drive power outside limit");

    // A restart leaves the loop state cleared
    a_restart_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_mv1 && (r_s1.command == plsu_pkg::CMD_RESTART)) |=> (r_state == '0))
        else $error("restart did not clear loop state");

    // After finish a sample does not touch the state
    a_frozen_when_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_mv1 && r_state.done_flag && (r_s1.command == plsu_pkg::CMD_SAMPLE))
        |=> $stable(r_state))
        else $error("loop state changed after finish");

    // Timer runs only once the near-target latch is set
    a_timer_needs_latch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_state.near_target_latch |-> (r_state.settle_timer == '0))
        else $error("settle timer running without latch");
`endif

endmodule

`default_nettype wire
